### rtl/twc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes, constants and micro-op tables of the time-walk correction block.
package twc_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = (IDX_W > 6) ? IDX_W : 6;
    localparam int KEY_W      = 28;
    localparam int SQRT_STEPS = 25;   // 50-bit radicand, two bits per step
    localparam int DIV_STEPS  = 48;   // 48-bit numerator, one bit per step

    // APB map: one 32-bit register
    localparam int         PADDR_W          = 3;
    localparam logic [0:0] REG_MIN_DISTANCE = 1'b0;

    // func codes
    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_WRITE = 3'd1;
    localparam logic [2:0] FN_FWD   = 3'd2;
    localparam logic [2:0] FN_REV   = 3'd3;
    localparam logic [2:0] FN_START = 3'd4;

    // method codes
    localparam logic [1:0] MT_NONE  = 2'd0;
    localparam logic [1:0] MT_ISQRT = 2'd1;
    localparam logic [1:0] MT_QUAD  = 2'd2;
    localparam logic [1:0] MT_NA    = 2'd3;

    // result status codes
    localparam logic [1:0] RS_OK        = 2'd0;
    localparam logic [1:0] RS_NO_ENTRY  = 2'd1;
    localparam logic [1:0] RS_FULL      = 2'd2;
    localparam logic [1:0] RS_NO_METHOD = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         crate_id;
        logic [7:0]         plane_id;
        logic [9:0]         segment;
        logic [1:0]         side;
        logic [1:0]         method;
        logic signed [31:0] coef_in_a;
        logic signed [31:0] coef_in_b;
        logic signed [31:0] coef_in_c;
        logic signed [31:0] value_main;
        logic signed [31:0] value_aux;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] corrected;
        logic               found;
        logic [1:0]         status;
    } out_item_t;

    // one table entry as stored in RAM
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [1:0]         method;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
    } ent_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_STEP,
        OP_MUL_C0W,
        OP_MUL_C1W,
        OP_MUL_WW,
        OP_MUL_C0LO,
        OP_MUL_C0HI,
        OP_MAG_Q,
        OP_MAG_PROD,
        OP_MAG_HI,
        OP_ACC_SUB_MAG,
        OP_ACC_ADD_MAG,
        OP_ACC_ADD_C2,
        OP_ACC_SUB_C2,
        OP_ACC_SUB_C1
    } dp_op_t;

    typedef enum logic [1:0] {
        PRG_FWD1,
        PRG_REV1,
        PRG_START,
        PRG_FWD2
    } prog_t;

    typedef struct packed {
        logic             capture;
        logic             clear_tab;
        logic             scan_start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_entry;
        logic             acc_main;
        logic             acc_zero;
        logic             set_flags;
        logic             found;
        logic [1:0]       status;
        dp_op_t           op;
        logic             emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] method;
        logic       hit;
        logic       free;
        logic       match_now;
        logic       scan_end;
    } dp_stat_t;

    // side | plane | crate | segment
    function automatic logic [KEY_W-1:0] make_key(input in_item_t it);
        make_key = {it.side, it.plane_id, it.crate_id, it.segment};
    endfunction

    function automatic logic [3:0] tail_last(input prog_t p);
        unique case (p)
            PRG_FWD1:  tail_last = 4'd2;
            PRG_REV1:  tail_last = 4'd2;
            PRG_START: tail_last = 4'd3;
            PRG_FWD2:  tail_last = 4'd8;
            default:   tail_last = 4'd0;
        endcase
    endfunction

    // closing op sequence of each rule
    function automatic dp_op_t tail_op(input prog_t p, input logic [3:0] i);
        dp_op_t o;
        o = OP_NONE;
        unique case (p)
            PRG_FWD1:
            begin
                unique case (i)
                    4'd0:    o = OP_MAG_Q;
                    4'd1:    o = OP_ACC_SUB_MAG;
                    4'd2:    o = OP_ACC_ADD_C2;
                    default: o = OP_NONE;
                endcase
            end
            PRG_REV1:
            begin
                unique case (i)
                    4'd0:    o = OP_MAG_Q;
                    4'd1:    o = OP_ACC_ADD_MAG;
                    4'd2:    o = OP_ACC_SUB_C2;
                    default: o = OP_NONE;
                endcase
            end
            PRG_START:
            begin
                unique case (i)
                    4'd0:    o = OP_MUL_C0W;
                    4'd1:    o = OP_MAG_PROD;
                    4'd2:    o = OP_ACC_SUB_MAG;
                    4'd3:    o = OP_ACC_SUB_C1;
                    default: o = OP_NONE;
                endcase
            end
            PRG_FWD2:
            begin
                unique case (i)
                    4'd0:    o = OP_MUL_WW;
                    4'd1:    o = OP_MUL_C0LO;
                    4'd2:    o = OP_MUL_C0HI;
                    4'd3:    o = OP_MAG_HI;
                    4'd4:    o = OP_ACC_SUB_MAG;
                    4'd5:    o = OP_MUL_C1W;
                    4'd6:    o = OP_MAG_PROD;
                    4'd7:    o = OP_ACC_SUB_MAG;
                    4'd8:    o = OP_ACC_SUB_C2;
                    default: o = OP_NONE;
                endcase
            end
            default: o = OP_NONE;
        endcase
        tail_op = o;
    endfunction

endpackage

### rtl/channel_time_walk_correction.sv
`timescale 1ns / 1ps
// Top level of the per-channel time-walk correction block.
//
// Input channel (in_valid / in_stall / in_data): one transfer per item. func selects
// clear, write entry, or one of the forward, reverse and start-time corrections.
// Output channel (out_valid / out_stall / out_data): exactly one result transfer per item.
// The APB port holds min_distance (byte address 0); pready is always high.
//
// One item is worked at a time; in_stall is low only while the controller is idle.
// The result sits in an output register, so the next item is taken while it waits.
// Work per item, from input transfer to result valid:
//   clear or unused func: no table scan
//   write or lookup: a table scan (one table entry read and compared per cycle)
//   inverse-sqrt rules: add 25 root steps + 48 divide steps + closing ops (bit-serial units)
//   start-time and quadratic rules: add closing ops only (one 32x32 multiplier, shared)
// Reset empties the table (valid bits cleared at once, no sweep) and sets min_distance to 1.
// A stalled result holds out_data; the block then finishes the next item and waits.
module channel_time_walk_correction (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  twc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output twc_pkg::out_item_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import twc_pkg::*;

    logic [16:0] min_dist_reg;
    logic        cfg_wr;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // register write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= 17'd1;
        end
        else if (cfg_wr && (paddr[2] == REG_MIN_DISTANCE))
        begin
            min_dist_reg <= pwdata[16:0];
        end
    end

    assign prdata = (paddr[2] == REG_MIN_DISTANCE) ? {15'd0, min_dist_reg} : 32'd0;

    twc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    twc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_data      (in_data),
        .min_distance (min_dist_reg),
        .out_data     (out_data)
    );
endmodule

### rtl/twc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module twc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/twc_dp.sv
`timescale 1ns / 1ps
// Datapath: entry table, key compare, square root, divider, multiplier and accumulator.
module twc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  twc_pkg::dp_cmd_t  cmd,
    output twc_pkg::dp_stat_t stat,
    input  twc_pkg::in_item_t in_data,
    input  logic [16:0]       min_distance,
    output twc_pkg::out_item_t out_data
);
    import twc_pkg::*;

    in_item_t                item_reg;
    ent_t                    ent_reg;
    ent_t                    rd_ent;
    ent_t                    wr_ent;
    logic [$bits(ent_t)-1:0] rd_word;
    logic [KEY_W-1:0]        key_now;

    logic [ENTRIES-1:0] valid_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   addr_d_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   wr_addr;
    logic               hit_reg;
    logic               free_reg;
    logic               match_now;

    logic signed [65:0] acc_reg;
    logic [63:0]        prod_reg;
    logic               prod_neg_reg;
    logic [63:0]        lo_reg;
    logic [14:0]        w2hi_reg;
    logic [63:0]        mag_reg;
    logic               mag_neg_reg;
    logic               found_reg;
    logic [1:0]         status_reg;
    out_item_t          out_reg;

    logic [49:0] rad_reg;
    logic [24:0] root_reg;
    logic [26:0] srem_reg;
    logic [47:0] num_reg;
    logic [24:0] drem_reg;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic               mul_neg;
    logic signed [32:0] diff;
    logic [32:0]        dabs;
    logic [16:0]        fl;
    logic [32:0]        dsel;
    logic [28:0]        srem_n;
    logic [28:0]        trial;
    logic               sq_ge;
    logic [25:0]        dt;
    logic               dv_ge;
    logic [79:0]        hsum;
    logic signed [65:0] mag66;
    logic               sat_hi;
    logic               sat_lo;
    logic [31:0]        sat_val;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : v;
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
        sx66 = {{34{v[31]}}, v};
    endfunction

    // ---------------- table ----------------
    assign key_now = make_key(item_reg);
    assign wr_addr = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        wr_ent        = '0;
        wr_ent.key    = key_now;
        wr_ent.method = item_reg.method;
        wr_ent.c0     = item_reg.coef_in_a;
        wr_ent.c1     = item_reg.coef_in_b;
        wr_ent.c2     = item_reg.coef_in_c;
    end

    twc_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_entry),
        .waddr (wr_addr),
        .wdata (wr_ent),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr),
        .rdata (rd_word)
    );

    assign rd_ent    = ent_t'(rd_word);
    assign match_now = pend_reg && valid_reg[addr_d_reg] && (rd_ent.key == key_now);

    always_comb
    begin
        stat           = '0;
        stat.func      = item_reg.func;
        stat.method    = ent_reg.method;
        stat.hit       = hit_reg;
        stat.free      = free_reg;
        stat.match_now = match_now;
        stat.scan_end  = pend_reg && (addr_d_reg == IDX_W'(ENTRIES - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.rd_en;
            if (cmd.clear_tab)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_entry)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (match_now)
                begin
                    hit_reg <= 1'b1;
                end
                if (pend_reg && !valid_reg[addr_d_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.rd_en)
        begin
            addr_d_reg <= cmd.rd_addr;
        end
        if (match_now)
        begin
            hit_idx_reg <= addr_d_reg;
            ent_reg     <= rd_ent;
        end
        if (pend_reg && !valid_reg[addr_d_reg] && !free_reg)
        begin
            free_idx_reg <= addr_d_reg;
        end
    end

    // ---------------- arithmetic ----------------
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.op)
            OP_MUL_C0W:
            begin
                mul_a   = mag32(ent_reg.c0);
                mul_b   = mag32(item_reg.value_aux);
                mul_neg = ent_reg.c0[31] ^ item_reg.value_aux[31];
            end
            OP_MUL_C1W:
            begin
                mul_a   = mag32(ent_reg.c1);
                mul_b   = mag32(item_reg.value_aux);
                mul_neg = ent_reg.c1[31] ^ item_reg.value_aux[31];
            end
            OP_MUL_WW:
            begin
                mul_a = mag32(item_reg.value_aux);
                mul_b = mag32(item_reg.value_aux);
            end
            OP_MUL_C0LO:
            begin
                mul_a   = mag32(ent_reg.c0);
                mul_b   = prod_reg[47:16];
                mul_neg = ent_reg.c0[31];
            end
            OP_MUL_C0HI:
            begin
                mul_a   = mag32(ent_reg.c0);
                mul_b   = {17'd0, w2hi_reg};
                mul_neg = ent_reg.c0[31];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // radicand: max(|de - c1|, floor) in Q16.16, shifted up 16
    assign diff = {item_reg.value_aux[31], item_reg.value_aux} - {ent_reg.c1[31], ent_reg.c1};
    assign dabs = diff[32] ? 33'(-diff) : 33'(diff);
    assign fl   = (min_distance == 17'd0) ? 17'd1 : min_distance;
    assign dsel = (dabs < {16'd0, fl}) ? {16'd0, fl} : dabs;

    assign srem_n = {srem_reg, rad_reg[49:48]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge  = (srem_n >= trial);

    assign dt    = {drem_reg, num_reg[47]};
    assign dv_ge = (dt >= {1'b0, root_reg});

    assign hsum  = {16'd0, lo_reg} + {prod_reg[47:0], 32'd0};
    assign mag66 = $signed({2'b00, mag_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.acc_zero)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_main)
        begin
            acc_reg <= sx66(item_reg.value_main);
        end
        if (cmd.set_flags)
        begin
            found_reg  <= cmd.found;
            status_reg <= cmd.status;
        end
        case (cmd.op) inside
            OP_SQRT_INIT:
            begin
                rad_reg  <= {1'b0, dsel, 16'd0};
                root_reg <= '0;
                srem_reg <= '0;
                num_reg  <= {mag32(ent_reg.c0), 16'd0};
                drem_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                srem_reg <= sq_ge ? 27'(srem_n - trial) : srem_n[26:0];
                root_reg <= {root_reg[23:0], sq_ge};
                rad_reg  <= {rad_reg[47:0], 2'b00};
            end
            OP_DIV_STEP:
            begin
                drem_reg <= dv_ge ? 25'(dt - {1'b0, root_reg}) : dt[24:0];
                num_reg  <= {num_reg[46:0], dv_ge};
            end
            OP_MUL_C0W, OP_MUL_C1W, OP_MUL_WW, OP_MUL_C0LO:
            begin
                prod_reg     <= mul_p;
                prod_neg_reg <= mul_neg;
                w2hi_reg     <= prod_reg[62:48];
            end
            OP_MUL_C0HI:
            begin
                prod_reg     <= mul_p;
                prod_neg_reg <= mul_neg;
                lo_reg       <= prod_reg;
            end
            OP_MAG_Q:
            begin
                mag_reg     <= {16'd0, num_reg};
                mag_neg_reg <= ent_reg.c0[31];
            end
            OP_MAG_PROD:
            begin
                mag_reg     <= {16'd0, prod_reg[63:16]};
                mag_neg_reg <= prod_neg_reg;
            end
            OP_MAG_HI:
            begin
                mag_reg     <= hsum[79:16];
                mag_neg_reg <= prod_neg_reg;
            end
            OP_ACC_SUB_MAG:
            begin
                acc_reg <= mag_neg_reg ? acc_reg + mag66 : acc_reg - mag66;
            end
            OP_ACC_ADD_MAG:
            begin
                acc_reg <= mag_neg_reg ? acc_reg - mag66 : acc_reg + mag66;
            end
            OP_ACC_ADD_C2:
            begin
                acc_reg <= acc_reg + sx66(ent_reg.c2);
            end
            OP_ACC_SUB_C2:
            begin
                acc_reg <= acc_reg - sx66(ent_reg.c2);
            end
            OP_ACC_SUB_C1:
            begin
                acc_reg <= acc_reg - sx66(ent_reg.c1);
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- result ----------------
    assign sat_hi  = !acc_reg[65] && (acc_reg[64:31] != '0);
    assign sat_lo  = acc_reg[65] && (acc_reg[64:31] != '1);
    assign sat_val = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : acc_reg[31:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.corrected <= sat_val;
            out_reg.found     <= found_reg;
            out_reg.status    <= status_reg;
        end
    end

    assign out_data = out_reg;
endmodule

### rtl/twc_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences table scan, lookup decision and arithmetic steps.
module twc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  twc_pkg::dp_stat_t stat,
    output twc_pkg::dp_cmd_t  cmd
);
    import twc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_EVAL  = 8'b0000_1000,
        ST_SQRT  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_TAIL  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    prog_t            prog_reg;
    prog_t            prog_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prog_next  = prog_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.func == FN_CLEAR)
                begin
                    cmd.clear_tab = 1'b1;
                    cmd.acc_zero  = 1'b1;
                    cmd.set_flags = 1'b1;
                    cmd.status    = RS_OK;
                    state_next    = ST_DONE;
                end
                else if (stat.func == FN_WRITE || stat.func == FN_FWD ||
                         stat.func == FN_REV || stat.func == FN_START)
                begin
                    cmd.scan_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    // unused codes pass the value through
                    cmd.acc_main  = 1'b1;
                    cmd.set_flags = 1'b1;
                    cmd.status    = RS_OK;
                    state_next    = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (stat.match_now || stat.scan_end)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            ST_EVAL:
            begin
                cmd.set_flags = 1'b1;
                state_next    = ST_DONE;
                if (stat.func == FN_WRITE)
                begin
                    cmd.acc_zero = 1'b1;
                    cmd.found    = stat.hit;
                    if (stat.hit || stat.free)
                    begin
                        cmd.wr_entry = 1'b1;
                        cmd.status   = RS_OK;
                    end
                    else
                    begin
                        cmd.status = RS_FULL;
                    end
                end
                else
                begin
                    cmd.acc_main = 1'b1;
                    if (!stat.hit)
                    begin
                        cmd.status = RS_NO_ENTRY;
                    end
                    else
                    begin
                        cmd.found = 1'b1;
                        if (stat.method == MT_NONE)
                        begin
                            cmd.status = RS_OK;
                        end
                        else if (stat.method == MT_ISQRT)
                        begin
                            cmd.status = RS_OK;
                            cnt_next   = '0;
                            if (stat.func == FN_START)
                            begin
                                prog_next  = PRG_START;
                                state_next = ST_TAIL;
                            end
                            else
                            begin
                                cmd.op     = OP_SQRT_INIT;
                                prog_next  = (stat.func == FN_FWD) ? PRG_FWD1 : PRG_REV1;
                                state_next = ST_SQRT;
                            end
                        end
                        else if (stat.method == MT_QUAD && stat.func == FN_FWD)
                        begin
                            cmd.status = RS_OK;
                            cnt_next   = '0;
                            prog_next  = PRG_FWD2;
                            state_next = ST_TAIL;
                        end
                        else
                        begin
                            cmd.status = RS_NO_METHOD;
                        end
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_TAIL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                cmd.op = tail_op(prog_reg, cnt_reg[3:0]);
                if (cnt_reg[3:0] == tail_last(prog_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || cmd.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prog_reg      <= PRG_FWD1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prog_reg      <= prog_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
endmodule
